FILE: rtl/esl_pkg.sv
// Types and constants shared by the event slot table modules.
`timescale 1ns / 1ps

package esl_pkg;

  localparam logic [31:0] DESC_BASE     = 32'hF100_0000;
  localparam logic [31:0] MODE_CALLBACK = 32'h0000_1000;
  localparam logic [31:0] MODE_READY    = 32'h0000_2000;
  localparam logic [31:0] TABLE_FULL    = 32'hFFFF_FFFF;

  localparam logic [2:0] OP_OPEN    = 3'd0;
  localparam logic [2:0] OP_CLOSE   = 3'd1;
  localparam logic [2:0] OP_ENABLE  = 3'd2;
  localparam logic [2:0] OP_DISABLE = 3'd3;
  localparam logic [2:0] OP_TEST    = 3'd4;
  localparam logic [2:0] OP_WAIT    = 3'd5;
  localparam logic [2:0] OP_DELIVER = 3'd6;

  localparam logic [1:0] CODE_OTHER    = 2'd0;
  localparam logic [1:0] CODE_CALLBACK = 2'd1;
  localparam logic [1:0] CODE_READY    = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] arg_first;
    logic [31:0] arg_second;
    logic [31:0] arg_third;
  } req_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        blocked;
  } rsp_t;

  typedef struct packed {
    logic [31:0] evt_class;
    logic [31:0] spec;
    logic [1:0]  mode_code;
  } entry_t;

endpackage

FILE: rtl/esl_slot_mem.sv
// Slot data memory: class, spec and mode per slot, one write and one registered read.
`timescale 1ns / 1ps

module esl_slot_mem
  import esl_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/esl_rsp_reg.sv
// Output register that holds one finished response until it is taken.
`timescale 1ns / 1ps

module esl_rsp_reg
  import esl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load_valid,
  input  rsp_t load_data,
  output logic load_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  assign load_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_ready) begin
      rsp_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      rsp_data <= load_data;
    end
  end

endmodule

FILE: rtl/event_slot_table.sv
// Event slot table: request sequencer, slot flags and slot data memory.
// Close, enable, disable, bad descriptors and unused opcodes go from decode
// straight to done; test and wait on an enabled, ready slot add a mode read;
// open scans for the first free slot; deliver reads the memory one slot per cycle.
// One request is in progress at a time; the next is taken once the previous
// response sits in the output register. Reset clears all slot flags; the data
// memory is not cleared, as it is read only for allocated slots.
`timescale 1ns / 1ps

module event_slot_table
  import esl_pkg::*;
#(
  parameter int EVENT_SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  localparam int IW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(EVENT_SLOTS - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_MODE    = 3'd3;
  localparam logic [2:0] S_DLV     = 3'd4;
  localparam logic [2:0] S_DLV_END = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]             state;
  req_t                   cur;
  logic [IW-1:0]          cnt;
  logic [IW-1:0]          pidx;
  logic                   pend;
  logic [31:0]            result;
  logic                   blocked_r;
  logic [EVENT_SLOTS-1:0] allocated;
  logic [EVENT_SLOTS-1:0] enabled;
  logic [EVENT_SLOTS-1:0] ready;

  logic [31:0]   desc_off;
  logic [IW-1:0] slot_idx;
  logic          desc_ok;
  logic          load_ready;
  rsp_t          load_data;

  logic          mem_wr_en;
  logic [IW-1:0] mem_rd_addr;
  entry_t        mem_wr_data;
  entry_t        mem_rd_data;

  // Descriptor check on the held request
  assign desc_off = cur.arg_first - DESC_BASE;
  assign slot_idx = desc_off[IW-1:0];
  assign desc_ok  = (cur.arg_first >= DESC_BASE) && (desc_off < 32'(EVENT_SLOTS)) &&
                    allocated[slot_idx];

  assign req_ready = (state == S_IDLE);

  // Memory is written only during the open scan and its read data is used only in
  // other states, so a used read never overlaps a write to the same entry.
  always_comb begin
    mem_wr_en             = (state == S_SCAN) && !allocated[cnt];
    mem_wr_data.evt_class = cur.arg_first;
    mem_wr_data.spec      = cur.arg_second;
    if (cur.arg_third == MODE_READY) begin
      mem_wr_data.mode_code = CODE_READY;
    end else if (cur.arg_third == MODE_CALLBACK) begin
      mem_wr_data.mode_code = CODE_CALLBACK;
    end else begin
      mem_wr_data.mode_code = CODE_OTHER;
    end
    mem_rd_addr = (state == S_DECODE) ? slot_idx : cnt;
  end

  esl_slot_mem #(
    .DEPTH (EVENT_SLOTS),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (cnt),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      allocated <= '0;
      enabled   <= '0;
      ready     <= '0;
    end else begin
      pend <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req_data;
            cnt   <= '0;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          result    <= '0;
          blocked_r <= 1'b0;
          state     <= S_DONE;
          case (cur.opcode)
            OP_OPEN: begin
              state <= S_SCAN;
            end
            OP_CLOSE: begin
              if (desc_ok) begin
                allocated[slot_idx] <= 1'b0;
                enabled[slot_idx]   <= 1'b0;
                ready[slot_idx]     <= 1'b0;
                result              <= 32'd1;
              end
            end
            OP_ENABLE, OP_DISABLE: begin
              if (desc_ok) begin
                enabled[slot_idx] <= (cur.opcode == OP_ENABLE);
                ready[slot_idx]   <= 1'b0;
                result            <= 32'd1;
              end
            end
            OP_TEST, OP_WAIT: begin
              if (desc_ok && enabled[slot_idx]) begin
                if (ready[slot_idx]) begin
                  // mode is read from memory this cycle
                  state <= S_MODE;
                end else if (cur.opcode == OP_WAIT) begin
                  blocked_r <= 1'b1;
                end
              end
            end
            OP_DELIVER: begin
              state <= S_DLV;
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          if (!allocated[cnt]) begin
            allocated[cnt] <= 1'b1;
            enabled[cnt]   <= 1'b0;
            ready[cnt]     <= 1'b0;
            result         <= DESC_BASE + 32'(cnt);
            state          <= S_DONE;
          end else if (cnt == LAST) begin
            result <= TABLE_FULL;
            state  <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MODE: begin
          if (mem_rd_data.mode_code == CODE_READY) begin
            ready[slot_idx] <= 1'b0;
          end
          result <= 32'd1;
          state  <= S_DONE;
        end
        S_DLV: begin
          // issue a read per slot; its data is checked the cycle after
          pend <= 1'b1;
          pidx <= cnt;
          if (cnt == LAST) begin
            state <= S_DLV_END;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DLV_END: begin
          result <= 32'd1;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (load_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (pend && allocated[pidx] && enabled[pidx] &&
          (mem_rd_data.evt_class == cur.arg_first) && (mem_rd_data.spec == cur.arg_second)) begin
        if (mem_rd_data.mode_code == CODE_READY) begin
          ready[pidx] <= 1'b1;
        end else if (mem_rd_data.mode_code == CODE_CALLBACK) begin
          ready[pidx] <= 1'b0;
        end
      end
    end
  end

  assign load_data.result_value = result;
  assign load_data.blocked      = blocked_r;

  esl_rsp_reg u_rsp (
    .clk        (clk),
    .rst        (rst),
    .load_valid (state == S_DONE),
    .load_data  (load_data),
    .load_ready (load_ready),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp_data   (rsp_data)
  );

  a_flags_need_alloc: assert property (@(posedge clk) disable iff (rst)
    ((enabled | ready) & ~allocated) == '0)
    else $error("enabled or ready flag set on a free slot");

  a_open_allocates: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && cur.opcode == OP_OPEN && result != TABLE_FULL)
      |-> allocated[result[IW-1:0]])
    else $error("open returned a descriptor for a free slot");

  a_blocked_only_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && blocked_r) |-> (cur.opcode == OP_WAIT))
    else $error("blocked status on a request other than wait");

  a_pend_in_deliver: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_DLV || state == S_DLV_END))
    else $error("deliver read pending outside the deliver scan");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && cnt == LAST) |=> (state == S_DONE))
    else $error("open scan ran past the last slot");

endmodule
